@@ design/rbc_pkg.sv @@
// ----------------------------------------------------------------------------
// rbc_pkg
// Shared types, constants and the normalized multiply used by the RGBA16
// blend compositor.
// ----------------------------------------------------------------------------
package rbc_pkg;

  // Width of one color or alpha channel.
  localparam int unsigned ChanW = 16;
  // Width of the blend mode register.
  localparam int unsigned ModeW = 4;
  // Width of the exact per-channel result, signed, before truncation.
  localparam int unsigned ExactW = ChanW + 3;
  // Number of channels in one pixel.
  localparam int unsigned NumChan = 4;
  // Reset value of the blend mode register.
  localparam logic [ModeW-1:0] ModeReset = '0;

  typedef logic [ChanW-1:0] chan_t;
  typedef logic signed [ExactW-1:0] exact_t;

  // Blend modes as written to the configuration register.
  typedef enum logic [ModeW-1:0] {
    MODE_ADD      = 4'd0,
    MODE_SUB      = 4'd1,
    MODE_MUL      = 4'd2,
    MODE_MIN      = 4'd3,
    MODE_MAX      = 4'd4,
    MODE_SETALPHA = 4'd5,
    MODE_PREALPHA = 4'd6,
    MODE_OVER     = 4'd7,
    MODE_MULTIPLY = 4'd8,
    MODE_SCREEN   = 4'd9,
    MODE_DARKEN   = 4'd10,
    MODE_LIGHTEN  = 4'd11
  } mode_e;

  // Rounded a*b/65535: t = a*b + 32768, result = (t + (t >> 16)) >> 16.
  // The sum stays below 2^32, so 32 bits are enough and the result fits 16.
  function automatic chan_t nmul(chan_t a, chan_t b);
    logic [2*ChanW-1:0] t;
    logic [2*ChanW-1:0] u;
    t = (2*ChanW)'(a) * (2*ChanW)'(b) + (2*ChanW)'(32768);
    u = t + (t >> ChanW);
    return u[2*ChanW-1:ChanW];
  endfunction

endpackage

@@ design/rgba16_blend_compositor.sv @@
// ----------------------------------------------------------------------------
// rgba16_blend_compositor
// Per-pixel compositor for 16-bit RGBA: blends a background pixel with a
// sampled source pixel under the configured blend mode.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one background and one source pixel per beat
//   (in_valid_i / in_stall_o); the output channel carries the blended pixel
//   and the range_overflow flag (out_valid_o / out_stall_i).
//   The blend mode is written through cfg_valid_i / cfg_data_i, which is
//   always ready; write it only while no pixel is in flight.
//   The beat is captured in the input register, the four channel lanes
//   blend it in one pass, and the result register holds it on the output.
//   Throughput is one pixel per clock while the receiver does not stall,
//   set by the single pass through the lane multipliers.
//   When the receiver stalls, the result register holds its beat and the
//   input register keeps taking a beat as long as it can move forward or is
//   empty; once both are full, in_stall_o rises.
//   Reset empties both registers and sets the blend mode to add.
// ----------------------------------------------------------------------------
module rgba16_blend_compositor (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [rbc_pkg::ModeW-1:0]   cfg_data_i,
  // Input pixel pair
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [rbc_pkg::ChanW-1:0]   bg_red_i,
  input  logic [rbc_pkg::ChanW-1:0]   bg_green_i,
  input  logic [rbc_pkg::ChanW-1:0]   bg_blue_i,
  input  logic [rbc_pkg::ChanW-1:0]   bg_alpha_i,
  input  logic [rbc_pkg::ChanW-1:0]   src_red_i,
  input  logic [rbc_pkg::ChanW-1:0]   src_green_i,
  input  logic [rbc_pkg::ChanW-1:0]   src_blue_i,
  input  logic [rbc_pkg::ChanW-1:0]   src_alpha_i,
  // Blended pixel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [rbc_pkg::ChanW-1:0]   out_red_o,
  output logic [rbc_pkg::ChanW-1:0]   out_green_o,
  output logic [rbc_pkg::ChanW-1:0]   out_blue_o,
  output logic [rbc_pkg::ChanW-1:0]   out_alpha_o,
  output logic                        range_overflow_o
);
  import rbc_pkg::*;

  logic [ModeW-1:0]            mode_q;
  mode_e                       mode;
  logic                        in_valid_q;
  logic [NumChan-1:0][ChanW-1:0] bg_q;
  logic [NumChan-1:0][ChanW-1:0] src_q;
  logic [NumChan-1:0][ChanW-1:0] res_d;
  logic [NumChan-1:0][ChanW-1:0] res_q;
  logic [NumChan-1:0]          rng_d;
  logic                        ovf_q;
  logic                        out_valid_q;
  logic                        out_ready;
  logic                        in_ready;

  // Blend mode register; the port takes a write every cycle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeReset;
    end else if (cfg_valid_i) begin
      mode_q <= cfg_data_i;
    end
  end

  assign mode = mode_e'(mode_q);

  // Handshake: each register moves when the one after it can take a beat.
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign in_ready   = !in_valid_q || out_ready;
  assign in_stall_o = !in_ready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready) begin
      bg_q  <= {bg_alpha_i, bg_blue_i, bg_green_i, bg_red_i};
      src_q <= {src_alpha_i, src_blue_i, src_green_i, src_red_i};
    end
  end

  // One blend lane per channel; lane 3 is alpha.
  for (genvar c = 0; c < NumChan; c++) begin : g_lane
    rbc_lane u_lane (
      .mode_i      (mode),
      .is_alpha_i  (c == NumChan - 1),
      .bg_i        (bg_q[c]),
      .src_i       (src_q[c]),
      .bg_alpha_i  (bg_q[NumChan-1]),
      .src_alpha_i (src_q[NumChan-1]),
      .src_red_i   (src_q[0]),
      .src_green_i (src_q[1]),
      .result_o    (res_d[c]),
      .range_o     (rng_d[c])
    );
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q && out_ready) begin
      res_q <= res_d;
      ovf_q <= |rng_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_red_o        = res_q[0];
  assign out_green_o      = res_q[1];
  assign out_blue_o       = res_q[2];
  assign out_alpha_o      = res_q[3];
  assign range_overflow_o = ovf_q;

endmodule

@@ design/rbc_lane.sv @@
// ----------------------------------------------------------------------------
// rbc_lane
// Blends one channel of a pixel: three shared normalized multipliers whose
// operands are picked by the blend mode, then a sum, a compare and a
// truncation to 16 bits with an out-of-range flag.
// ----------------------------------------------------------------------------
module rbc_lane (
  input  rbc_pkg::mode_e mode_i,
  input  logic           is_alpha_i,
  input  rbc_pkg::chan_t bg_i,
  input  rbc_pkg::chan_t src_i,
  input  rbc_pkg::chan_t bg_alpha_i,
  input  rbc_pkg::chan_t src_alpha_i,
  input  rbc_pkg::chan_t src_red_i,
  input  rbc_pkg::chan_t src_green_i,
  output rbc_pkg::chan_t result_o,
  output logic           range_o
);
  import rbc_pkg::*;

  chan_t  x0, y0, x1, y1, x2, y2;
  chan_t  p0, p1, p2;
  exact_t b_x, s_x, p0_x, p1_x, p2_x;
  exact_t exact;
  logic   alpha_over;

  // The alpha channel of the compositing modes takes b_a + nmul(s_a, ~b_a).
  assign alpha_over = is_alpha_i && (mode_i == MODE_OVER || mode_i == MODE_MULTIPLY ||
                                     mode_i == MODE_DARKEN || mode_i == MODE_LIGHTEN);

  // Operand selection for the three multipliers.
  always_comb begin
    x0 = bg_i;
    y0 = src_i;
    x1 = ~bg_alpha_i;
    y1 = src_i;
    x2 = src_i;
    y2 = bg_i;
    if (alpha_over) begin
      x0 = src_alpha_i;
      y0 = ~bg_i;
    end else begin
      case (mode_i)
        MODE_PREALPHA: begin
          y0 = src_red_i;
        end
        MODE_OVER, MODE_MULTIPLY: begin
          x0 = ~src_alpha_i;
          y0 = bg_i;
        end
        MODE_SCREEN: begin
          x0 = src_i;
          y0 = ~bg_i;
        end
        MODE_DARKEN, MODE_LIGHTEN: begin
          x0 = src_i;
          y0 = bg_alpha_i;
          x1 = bg_i;
          y1 = src_alpha_i;
        end
        default: begin
          x0 = bg_i;
          y0 = src_i;
        end
      endcase
    end
  end

  assign p0 = nmul(x0, y0);
  assign p1 = nmul(x1, y1);
  assign p2 = nmul(x2, y2);

  assign b_x  = exact_t'(bg_i);
  assign s_x  = exact_t'(src_i);
  assign p0_x = exact_t'(p0);
  assign p1_x = exact_t'(p1);
  assign p2_x = exact_t'(p2);

  // Exact channel value, formed as a signed integer.
  always_comb begin
    exact = b_x;
    if (alpha_over) begin
      exact = b_x + p0_x;
    end else begin
      case (mode_i)
        MODE_ADD: begin
          exact = (b_x + s_x > exact_t'(65535)) ? exact_t'(65535) : b_x + s_x;
        end
        MODE_SUB: begin
          exact = (b_x > s_x) ? b_x - s_x : '0;
        end
        MODE_MUL: begin
          exact = p0_x;
        end
        MODE_MIN: begin
          exact = (b_x < s_x) ? b_x : s_x;
        end
        MODE_MAX: begin
          exact = (b_x > s_x) ? b_x : s_x;
        end
        MODE_SETALPHA: begin
          exact = is_alpha_i ? exact_t'(src_red_i) : b_x;
        end
        MODE_PREALPHA: begin
          exact = is_alpha_i ? exact_t'(src_green_i) : p0_x;
        end
        MODE_OVER: begin
          exact = p0_x + s_x;
        end
        MODE_MULTIPLY: begin
          exact = p0_x + p1_x + p2_x;
        end
        MODE_SCREEN: begin
          exact = b_x + p0_x;
        end
        MODE_DARKEN: begin
          exact = b_x + s_x - ((p0_x > p1_x) ? p0_x : p1_x);
        end
        MODE_LIGHTEN: begin
          exact = b_x + s_x - ((p0_x < p1_x) ? p0_x : p1_x);
        end
        default: begin
          exact = b_x;
        end
      endcase
    end
  end

  // Keep the low 16 bits; flag anything below zero or above 65535.
  assign result_o = exact[ChanW-1:0];
  assign range_o  = |exact[ExactW-1:ChanW];

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Testbench for the RGBA16 blend compositor. Pixel pairs are driven through
// the input channel under every blend code, unused codes included. Each
// accepted beat is predicted by an independent channel-by-channel blend
// calculation. Each blended pixel that leaves the block is checked in order
// against those predictions, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rbc_pkg::*;

  // Full-scale channel value and the rounding offset of the scaled multiply.
  localparam longint ChanMax = 65535;
  localparam longint RoundHalf = 32768;
  localparam int unsigned NumModes = 2 ** ModeW;
  // Random pixel pairs sent per blend code in each idling phase.
  localparam int unsigned PairsPerMode = 12;
  // Cycles without any accepted beat before the run is declared hung.
  localparam int unsigned HangLimit = 2000;
  // Cycles kept after the last result.
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned MaxReports = 10;

  // Channel index 0 is red, then green, blue and alpha.
  localparam int unsigned Red = 0;
  localparam int unsigned Green = 1;
  localparam int unsigned Blue = 2;
  localparam int unsigned Alpha = 3;

  typedef struct packed {
    chan_t [NumChan-1:0] bg;
    chan_t [NumChan-1:0] src;
  } pixel_pair_t;

  typedef struct packed {
    chan_t [NumChan-1:0] chan;
    logic                ovf;
  } blend_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [ModeW-1:0]  cfg_data_i;
  logic              in_valid_i;
  logic              in_stall_o;
  pixel_pair_t       in_px;
  logic              out_valid_o;
  logic              out_stall_i;
  chan_t             out_red_o;
  chan_t             out_green_o;
  chan_t             out_blue_o;
  chan_t             out_alpha_o;
  logic              range_overflow_o;

  // Blend code the block holds, tracked on every accepted write.
  logic [ModeW-1:0]  cur_mode;
  blend_t            blend_q[$];
  int unsigned       fail_cnt = 0;
  int unsigned       send_idle_pct;
  int unsigned       recv_idle_pct;
  int unsigned       quiet_cycles = 0;

  rgba16_blend_compositor i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .bg_red_i         (in_px.bg[Red]),
    .bg_green_i       (in_px.bg[Green]),
    .bg_blue_i        (in_px.bg[Blue]),
    .bg_alpha_i       (in_px.bg[Alpha]),
    .src_red_i        (in_px.src[Red]),
    .src_green_i      (in_px.src[Green]),
    .src_blue_i       (in_px.src[Blue]),
    .src_alpha_i      (in_px.src[Alpha]),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_red_o        (out_red_o),
    .out_green_o      (out_green_o),
    .out_blue_o       (out_blue_o),
    .out_alpha_o      (out_alpha_o),
    .range_overflow_o (range_overflow_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Rounded a*b/65535, worked out in 64-bit arithmetic.
  function automatic longint scale_mul(longint a, longint b);
    longint t;
    t = a * b + RoundHalf;
    return (t + (t >>> ChanW)) >>> ChanW;
  endfunction

  // Expected blended pixel for one pair under the given blend code.
  function automatic blend_t blend_predict(logic [ModeW-1:0] mode, pixel_pair_t px);
    longint b[NumChan];
    longint s[NumChan];
    longint r[NumChan];
    longint ba;
    longint sa;
    longint alpha_over;
    longint p;
    longint q;
    blend_t res;
    for (int i = 0; i < NumChan; i++) begin
      b[i] = longint'(px.bg[i]);
      s[i] = longint'(px.src[i]);
      r[i] = b[i];
    end
    ba = b[Alpha];
    sa = s[Alpha];
    alpha_over = ba + scale_mul(sa, ChanMax - ba);
    case (mode)
      MODE_ADD: begin
        for (int i = 0; i < NumChan; i++) r[i] = (b[i] + s[i] > ChanMax) ? ChanMax : b[i] + s[i];
      end
      MODE_SUB: begin
        for (int i = 0; i < NumChan; i++) r[i] = (b[i] < s[i]) ? 0 : b[i] - s[i];
      end
      MODE_MUL: begin
        for (int i = 0; i < NumChan; i++) r[i] = scale_mul(b[i], s[i]);
      end
      MODE_MIN: begin
        for (int i = 0; i < NumChan; i++) r[i] = (b[i] < s[i]) ? b[i] : s[i];
      end
      MODE_MAX: begin
        for (int i = 0; i < NumChan; i++) r[i] = (b[i] > s[i]) ? b[i] : s[i];
      end
      MODE_SETALPHA: begin
        r[Alpha] = s[Red];
      end
      MODE_PREALPHA: begin
        for (int i = 0; i < Alpha; i++) r[i] = scale_mul(b[i], s[Red]);
        r[Alpha] = s[Green];
      end
      MODE_OVER: begin
        for (int i = 0; i < Alpha; i++) r[i] = scale_mul(ChanMax - sa, b[i]) + s[i];
        r[Alpha] = alpha_over;
      end
      MODE_MULTIPLY: begin
        for (int i = 0; i < Alpha; i++) begin
          r[i] = scale_mul(ChanMax - sa, b[i]) + scale_mul(ChanMax - ba, s[i])
                 + scale_mul(s[i], b[i]);
        end
        r[Alpha] = alpha_over;
      end
      MODE_SCREEN: begin
        for (int i = 0; i < NumChan; i++) r[i] = b[i] + scale_mul(s[i], ChanMax - b[i]);
      end
      MODE_DARKEN, MODE_LIGHTEN: begin
        // Darken removes the larger cross product, lighten the smaller one.
        for (int i = 0; i < Alpha; i++) begin
          p = scale_mul(s[i], ba);
          q = scale_mul(b[i], sa);
          if ((mode == MODE_DARKEN) == (p > q)) r[i] = b[i] + s[i] - p;
          else r[i] = b[i] + s[i] - q;
        end
        r[Alpha] = alpha_over;
      end
      default: begin
        // Unused codes pass the background through untouched.
      end
    endcase
    res.ovf = 1'b0;
    for (int i = 0; i < NumChan; i++) begin
      if (r[i] < 0 || r[i] > ChanMax) res.ovf = 1'b1;
      res.chan[i] = chan_t'(r[i]);
    end
    return res;
  endfunction

  // Channel value biased toward the ends of the range.
  function automatic chan_t rand_chan();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return chan_t'($urandom_range(ChanMax));
    endcase
  endfunction

  function automatic pixel_pair_t rand_pair();
    pixel_pair_t px;
    for (int i = 0; i < NumChan; i++) begin
      px.bg[i] = rand_chan();
      px.src[i] = rand_chan();
    end
    return px;
  endfunction

  function automatic pixel_pair_t make_pair(chan_t br, chan_t bgr, chan_t bb, chan_t bal,
                                            chan_t sr, chan_t sg, chan_t sb, chan_t sal);
    pixel_pair_t px;
    px.bg = {bal, bb, bgr, br};
    px.src = {sal, sb, sg, sr};
    return px;
  endfunction

  // Record a failure; only the first few are described.
  function automatic void note_failure(string what, blend_t want, blend_t got);
    fail_cnt++;
    if (fail_cnt <= MaxReports) begin
      $display("%0t: %s: expected r=%h g=%h b=%h a=%h ovf=%b, got r=%h g=%h b=%h a=%h ovf=%b",
               $realtime, what, want.chan[Red], want.chan[Green], want.chan[Blue],
               want.chan[Alpha], want.ovf, got.chan[Red], got.chan[Green], got.chan[Blue],
               got.chan[Alpha], got.ovf);
    end
  endfunction

  // Predict every pixel beat accepted on the input channel.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) blend_q.push_back(blend_predict(cur_mode, in_px));
  end

  // Check every blended beat against the oldest prediction.
  always @(posedge clk_i) begin : check_blends
    blend_t got;
    blend_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.chan = {out_alpha_o, out_blue_o, out_green_o, out_red_o};
      got.ovf = range_overflow_o;
      if (blend_q.size() == 0) begin
        note_failure("unexpected beat", '0, got);
      end else begin
        want = blend_q.pop_front();
        if (got.chan[Red] !== want.chan[Red] || got.chan[Green] !== want.chan[Green] ||
            got.chan[Blue] !== want.chan[Blue] || got.chan[Alpha] !== want.chan[Alpha] ||
            got.ovf !== want.ovf) begin
          note_failure("mismatch", want, got);
        end
      end
    end
  end

  // Hang detection: any accepted beat on any channel restarts the count.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= HangLimit) begin
      $display("%0t: no beat accepted for %0d cycles", $realtime, HangLimit);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: stall at random at the configured rate.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Send one pixel pair; valid is left high so back-to-back beats can follow.
  task automatic send_pair(pixel_pair_t px);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_px <= px;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic stop_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Change the blend code once every pixel in flight has come out.
  task automatic write_mode(logic [ModeW-1:0] mode);
    stop_input();
    while (blend_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= mode;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cur_mode = mode;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Extremes and alternating bit patterns under the reset blend code (add).
  task automatic test_reset_mode_extremes();
    send_pair(make_pair('0, '0, '0, '0, '0, '0, '0, '0));
    send_pair(make_pair('1, '1, '1, '1, '1, '1, '1, '1));
    send_pair(make_pair('1, '1, '1, '1, '0, '0, '0, '0));
    send_pair(make_pair('0, '0, '0, '0, '1, '1, '1, '1));
    send_pair(make_pair(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                        16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
  endtask

  // One mixed pair under every code, unused ones included; the pair makes
  // over, multiply, darken and lighten leave the channel range.
  task automatic test_mode_sweep();
    for (int code = 0; code < NumModes; code++) begin
      write_mode(ModeW'(code));
      send_pair(make_pair(16'hFFFF, 16'h8000, 16'h0001, 16'h4000,
                          16'h8000, 16'hFFFF, 16'h0000, 16'hC000));
    end
  endtask

  // Random pairs under every code in random order, at the given idle rates.
  task automatic test_random_blends(int unsigned send_pct, int unsigned recv_pct);
    int unsigned order[NumModes];
    int unsigned j;
    int unsigned tmp;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < NumModes; i++) order[i] = i;
    for (int i = NumModes - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < NumModes; i++) begin
      write_mode(ModeW'(order[i]));
      for (int k = 0; k < PairsPerMode; k++) send_pair(rand_pair());
    end
  endtask

  // Main sequence.
  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_px = '0;
    cur_mode = ModeReset;
    send_idle_pct = 23;
    recv_idle_pct = 64;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_mode_extremes();
    test_mode_sweep();
    test_random_blends(23, 64);
    test_random_blends(64, 23);
    test_random_blends(0, 0);

    stop_input();
    while (blend_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_cnt == 0 && blend_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
